FILE: src/cawc_pkg.sv
`default_nettype none
package cawc_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 256;
	localparam int unsigned CODE_W = 26;
	localparam int unsigned FAC_W = 8;
	localparam int unsigned CARD_W = 16;
	localparam int unsigned KEY_W = FAC_W + CARD_W;
	localparam int unsigned CNT_W = 16;
	localparam int unsigned HELD_W = 9;
	localparam int unsigned IN_DATA_W = 56;
	localparam int unsigned OUT_DATA_W = 88;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
	localparam logic [CNT_W-1:0] THRESH_RESET = 16'd10;

	typedef enum logic [1:0] {
		MODE_ATTEMPT = 2'd0,
		MODE_APPEND  = 2'd1,
		MODE_CLEAR   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_GRANTED = 3'd0,
		ST_PARITY  = 3'd1,
		ST_DENIED  = 3'd2,
		ST_STORED  = 3'd3,
		ST_FULL    = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESULT
	} fsm_t;

	typedef struct packed {
		logic              ok;
		logic [FAC_W-1:0]  fac;
		logic [CARD_W-1:0] card;
	} parse_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + CNT_W'(1);
	endfunction

endpackage
`default_nettype wire

FILE: src/cawc_parse.sv
`default_nettype none
module cawc_parse (
	input  wire logic [cawc_pkg::CODE_W-1:0] code,
	output cawc_pkg::parse_t                 parsed
);

	// upper half even, lower half odd
	always_comb begin
		parsed.ok   = ~(^code[25:13]) & (^code[12:0]);
		parsed.fac  = code[24:17];
		parsed.card = code[16:1];
	end

endmodule
`default_nettype wire

FILE: src/cawc_scan.sv
`default_nettype none
module cawc_scan #(
	parameter int unsigned TABLE_DEPTH = cawc_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      start,
	input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]          count,
	input  wire logic [cawc_pkg::KEY_W-1:0]                key,
	input  wire logic                                      wr_en,
	input  wire logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [cawc_pkg::KEY_W-1:0]                wr_data,
	output cawc_pkg::scan_res_t                            res
);

	localparam int unsigned ECNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [cawc_pkg::KEY_W-1:0] mem [TABLE_DEPTH];
	logic [cawc_pkg::KEY_W-1:0] rd_data_s1;
	logic [ECNT_W-1:0]          addr_q;
	logic [ECNT_W-1:0]          addr_nxt;
	logic                       busy_q;
	logic                       rd_valid_s1;
	logic                       last_s1;
	logic                       hit_q;
	logic                       last_issue;
	logic                       match;

	assign addr_nxt   = addr_q + ECNT_W'(1);
	assign last_issue = (addr_nxt == count);
	assign match      = rd_valid_s1 && (rd_data_s1 == key);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (busy_q) begin
			rd_data_s1 <= mem[addr_q[IDX_W-1:0]];
		end
	end

	// one entry read per cycle, compared in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
			last_s1     <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			rd_valid_s1 <= busy_q;
			last_s1     <= busy_q && last_issue;
			if (start) begin
				busy_q <= 1'b1;
				addr_q <= '0;
				hit_q  <= 1'b0;
			end else begin
				if (busy_q) begin
					addr_q <= addr_nxt;
					busy_q <= !last_issue;
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		res.done = rd_valid_s1 && last_s1;
		res.hit  = hit_q | match;
	end

endmodule
`default_nettype wire

FILE: src/card_access_whitelist_checker.sv
// Flow: an access attempt with good parity and a non-empty table scans the stored entries,
// one table entry read and compared per cycle, before its result is loaded.
// Append, clear and attempts with bad parity or an empty table load their result without a scan.
// Throughput: one item at a time; the next beat is taken the cycle after the result is
// loaded, and a result is loaded only once an earlier result has been taken (tready).
// Reset (arst_n low): counters, entry count and door flag clear, threshold returns to 10.
`default_nettype none
module card_access_whitelist_checker #(
	parameter int unsigned TABLE_DEPTH = cawc_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [cawc_pkg::CNT_W-1:0]          cfg_wr_data,     // failed_threshold
	input  wire logic                                s_axis_tvalid,
	output      logic                                s_axis_tready,
	// frame[25:0], entry_facility[33:26], entry_card[49:34], zero pad
	input  wire logic [cawc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input  wire logic [1:0]                          s_axis_tuser,    // mode
	output      logic                                m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// granted[0], facility_out[8:1], card_out[24:9], door_unlocked[25], failed_count[41:26],
	// success_count[57:42], attempt_count[73:58], attack_warning[74], entries_held[83:75]
	output      logic [cawc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output      logic [2:0]                          m_axis_tuser     // status
);

	localparam int unsigned ECNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned PAD_W = cawc_pkg::OUT_DATA_W - 84;

	cawc_pkg::fsm_t      state_q, state_nxt;
	cawc_pkg::parse_t    parse_in, parse_q;
	cawc_pkg::scan_res_t scan_res;
	cawc_pkg::status_t   status_nxt;

	logic [1:0]                    mode_q;
	logic [cawc_pkg::KEY_W-1:0]    entry_q;
	logic                          hit_q;
	logic [ECNT_W-1:0]             count_q, count_nxt;
	logic                          door_q, door_nxt;
	logic [cawc_pkg::CNT_W-1:0]    fail_q, fail_nxt;
	logic [cawc_pkg::CNT_W-1:0]    grant_q, grant_nxt;
	logic [cawc_pkg::CNT_W-1:0]    try_q, try_nxt;
	logic [cawc_pkg::CNT_W-1:0]    thresh_q;
	logic                          m_valid_q;
	logic [cawc_pkg::OUT_DATA_W-1:0] m_data_q;
	logic [2:0]                    m_user_q;

	logic in_beat;
	logic out_free;
	logic scan_start;
	logic finish;
	logic mem_wr;
	logic is_att;
	logic grant;
	logic full;
	logic [cawc_pkg::FAC_W-1:0]  fac_res;
	logic [cawc_pkg::CARD_W-1:0] card_res;

	cawc_parse u_parse (
		.code   (s_axis_tdata[cawc_pkg::CODE_W-1:0]),
		.parsed (parse_in)
	);

	cawc_scan #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.count   (count_q),
		.key     ({parse_q.fac, parse_q.card}),
		.wr_en   (mem_wr),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (entry_q),
		.res     (scan_res)
	);

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign full     = (count_q == ECNT_W'(TABLE_DEPTH));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cawc_pkg::S_IDLE: begin
				if (s_axis_tvalid) begin
					unique case (s_axis_tuser)
						cawc_pkg::MODE_ATTEMPT: begin
							state_nxt = (parse_in.ok && count_q != '0) ?
								cawc_pkg::S_SCAN : cawc_pkg::S_RESULT;
						end
						cawc_pkg::MODE_APPEND, cawc_pkg::MODE_CLEAR: begin
							state_nxt = cawc_pkg::S_RESULT;
						end
						default: begin
							state_nxt = cawc_pkg::S_IDLE;  // unknown mode is dropped
						end
					endcase
				end
			end
			cawc_pkg::S_SCAN: begin
				if (scan_res.done) begin
					state_nxt = cawc_pkg::S_RESULT;
				end
			end
			cawc_pkg::S_RESULT: begin
				if (out_free) begin
					state_nxt = cawc_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = cawc_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		scan_start    = 1'b0;
		finish        = 1'b0;
		unique case (state_q)
			cawc_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				scan_start    = s_axis_tvalid && (s_axis_tuser == cawc_pkg::MODE_ATTEMPT) &&
					parse_in.ok && (count_q != '0);
			end
			cawc_pkg::S_SCAN: begin
			end
			cawc_pkg::S_RESULT: begin
				finish = out_free;
			end
			default: begin
			end
		endcase
	end

	assign mem_wr = finish && (mode_q == cawc_pkg::MODE_APPEND) && !full;

	// result and next state of the item in hand
	always_comb begin
		is_att    = (mode_q == cawc_pkg::MODE_ATTEMPT);
		grant     = is_att && parse_q.ok && hit_q;
		door_nxt  = door_q | grant;
		try_nxt   = is_att ? cawc_pkg::sat_inc(try_q) : try_q;
		grant_nxt = grant ? cawc_pkg::sat_inc(grant_q) : grant_q;
		fail_nxt  = (is_att && !grant) ? cawc_pkg::sat_inc(fail_q) : fail_q;
		fac_res   = (is_att && parse_q.ok) ? parse_q.fac : '0;
		card_res  = (is_att && parse_q.ok) ? parse_q.card : '0;
		count_nxt = count_q;
		status_nxt = cawc_pkg::ST_CLEARED;
		unique case (mode_q)
			cawc_pkg::MODE_ATTEMPT: begin
				priority if (!parse_q.ok) begin
					status_nxt = cawc_pkg::ST_PARITY;
				end else if (hit_q) begin
					status_nxt = cawc_pkg::ST_GRANTED;
				end else begin
					status_nxt = cawc_pkg::ST_DENIED;
				end
			end
			cawc_pkg::MODE_APPEND: begin
				if (full) begin
					status_nxt = cawc_pkg::ST_FULL;
				end else begin
					status_nxt = cawc_pkg::ST_STORED;
					count_nxt  = count_q + ECNT_W'(1);
				end
			end
			default: begin
				status_nxt = cawc_pkg::ST_CLEARED;
				count_nxt  = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			mode_q  <= s_axis_tuser;
			parse_q <= parse_in;
			// facility above card, as in the search key
			entry_q <= {s_axis_tdata[33:26], s_axis_tdata[49:34]};
		end
		if (finish) begin
			m_data_q <= {{PAD_W{1'b0}}, cawc_pkg::HELD_W'(count_nxt), (fail_nxt > thresh_q),
				try_nxt, grant_nxt, fail_nxt, door_nxt, card_res, fac_res, grant};
			m_user_q <= status_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cawc_pkg::S_IDLE;
			hit_q     <= 1'b0;
			count_q   <= '0;
			door_q    <= 1'b0;
			fail_q    <= '0;
			grant_q   <= '0;
			try_q     <= '0;
			thresh_q  <= cawc_pkg::THRESH_RESET;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				thresh_q <= cfg_wr_data;
			end
			if (in_beat) begin
				hit_q <= 1'b0;
			end else if (state_q == cawc_pkg::S_SCAN && scan_res.done) begin
				hit_q <= scan_res.hit;
			end
			if (finish) begin
				count_q   <= count_nxt;
				door_q    <= door_nxt;
				fail_q    <= fail_nxt;
				grant_q   <= grant_nxt;
				try_q     <= try_nxt;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule
`default_nettype wire

FILE: verif/access_result_checker.sv
module access_result_checker
	import cawc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CNT_W-1:0]      cfg_wr_data,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	// frame[25:0], entry_facility[33:26], entry_card[49:34], zero pad
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic [1:0]            s_axis_tuser,    // mode
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// granted[0], facility_out[8:1], card_out[24:9], door_unlocked[25], failed_count[41:26],
	// success_count[57:42], attempt_count[73:58], attack_warning[74], entries_held[83:75]
	input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  wire logic [2:0]            m_axis_tuser,    // status
	output int                         outstanding,
	output int                         mismatches,
	output int                         checked
);

	localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

	typedef struct packed {
		logic              granted;
		status_t           status;
		logic [FAC_W-1:0]  fac;
		logic [CARD_W-1:0] card;
		logic              door;
		logic [CNT_W-1:0]  fails;
		logic [CNT_W-1:0]  grants;
		logic [CNT_W-1:0]  tries;
		logic              warn;
		logic [HELD_W-1:0] held;
	} verdict_t;

	// shadow of the controller state
	logic [KEY_W-1:0] roster [DEPTH];
	int unsigned      roster_len = 0;
	logic             door_open  = 1'b0;
	logic [CNT_W-1:0] fail_cnt   = '0;
	logic [CNT_W-1:0] grant_cnt  = '0;
	logic [CNT_W-1:0] try_cnt    = '0;
	logic [CNT_W-1:0] threshold  = THRESH_RESET;

	verdict_t due_verdicts [$];
	int       pending = 0;
	int       bad     = 0;
	int       seen    = 0;

	assign outstanding = pending;
	assign mismatches  = bad;
	assign checked     = seen;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	task automatic apply_item(input logic [1:0] mode, input logic [IN_DATA_W-1:0] d);
		logic [CODE_W-1:0] code;
		logic              hit;
		verdict_t          v;
		code = d[CODE_W-1:0];
		v = '0;
		case (mode)
			MODE_ATTEMPT: begin
				try_cnt = bump(try_cnt);
				// even ones over the upper half, odd ones over the lower half
				if ((^code[25:13]) || !(^code[12:0])) begin
					v.status = ST_PARITY;
					fail_cnt = bump(fail_cnt);
				end else begin
					v.fac  = code[24:17];
					v.card = code[16:1];
					hit = 1'b0;
					for (int i = 0; i < roster_len; i++)
						if (roster[i] == {v.fac, v.card})
							hit = 1'b1;
					if (hit) begin
						v.granted = 1'b1;
						v.status  = ST_GRANTED;
						door_open = 1'b1;
						grant_cnt = bump(grant_cnt);
					end else begin
						v.status = ST_DENIED;
						fail_cnt = bump(fail_cnt);
					end
				end
			end
			MODE_APPEND: begin
				if (roster_len < DEPTH) begin
					roster[roster_len] = {d[CODE_W +: FAC_W], d[CODE_W+FAC_W +: CARD_W]};
					roster_len++;
					v.status = ST_STORED;
				end else begin
					v.status = ST_FULL;
				end
			end
			MODE_CLEAR: begin
				roster_len = 0;
				v.status = ST_CLEARED;
			end
			default: return;    // unused mode: dropped, no result
		endcase
		v.door   = door_open;
		v.fails  = fail_cnt;
		v.grants = grant_cnt;
		v.tries  = try_cnt;
		v.warn   = fail_cnt > threshold;
		v.held   = HELD_W'(roster_len);
		due_verdicts.push_back(v);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			bad++;
		end
	endtask

	task automatic compare_result(input logic [OUT_DATA_W-1:0] d, input logic [2:0] st);
		verdict_t want;
		if (due_verdicts.size() == 0) begin
			$error("result beat with no expectation waiting");
			bad++;
			return;
		end
		want = due_verdicts.pop_front();
		seen++;
		check_field("granted",        32'(want.granted), 32'(d[0]));
		check_field("status",         32'(want.status),  32'(st));
		check_field("facility_out",   32'(want.fac),     32'(d[8:1]));
		check_field("card_out",       32'(want.card),    32'(d[24:9]));
		check_field("door_unlocked",  32'(want.door),    32'(d[25]));
		check_field("failed_count",   32'(want.fails),   32'(d[41:26]));
		check_field("success_count",  32'(want.grants),  32'(d[57:42]));
		check_field("attempt_count",  32'(want.tries),   32'(d[73:58]));
		check_field("attack_warning", 32'(want.warn),    32'(d[74]));
		check_field("entries_held",   32'(want.held),    32'(d[83:75]));
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			compare_result(m_axis_tdata, m_axis_tuser);
		if (cfg_wr_en)
			threshold = cfg_wr_data;
		if (s_axis_tvalid && s_axis_tready)
			apply_item(s_axis_tuser, s_axis_tdata);
		pending <= due_verdicts.size();
	end

endmodule

FILE: verif/tb_card_access_whitelist_checker.sv
module tb_card_access_whitelist_checker;
	import cawc_pkg::*;

	localparam int unsigned DEPTH         = TABLE_DEPTH_DEF;
	localparam int          RANDOM_ITEMS  = 1840;
	localparam int          SAT_ROUNDS    = 20;
	localparam int          HOLD_AT       = 300;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          SETTLE_CYCLES = 300;
	localparam int          STALL_LIMIT   = 5000;

	localparam logic [1:0]        MODE_UNUSED = 2'd3;
	localparam logic [CODE_W-1:0] BIT_EVEN    = 26'h2000000;
	localparam logic [CODE_W-1:0] BIT_ODD     = 26'h0000001;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_wr_en     = 1'b0;
	logic [CNT_W-1:0]      cfg_wr_data   = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [1:0]            s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [2:0]            m_axis_tuser;

	int outstanding;
	int mismatches;
	int checked;

	logic calm       = 1'b0;
	int   beats_sent = 0;
	int   hold_left  = 0;
	bit   hold_done  = 1'b0;
	int   quiet      = 0;
	int   n_attempt  = 0;
	int   n_append   = 0;
	int   n_clear    = 0;
	int   n_ignored  = 0;
	int   n_cfg      = 0;

	// keys the controller should now hold, so attempts can be aimed at them
	logic [KEY_W-1:0] stored_keys [$];

	always #6 clk = ~clk;

	card_access_whitelist_checker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	access_result_checker chk (
		.clk           (clk),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.outstanding   (outstanding),
		.mismatches    (mismatches),
		.checked       (checked)
	);

	// result side: random back-pressure, plus one long hold-off once traffic is flowing
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && beats_sent >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 14);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [CODE_W-1:0] wiegand(input logic [FAC_W-1:0] f,
			input logic [CARD_W-1:0] c);
		logic [CODE_W-1:0] w;
		w = {1'b0, f, c, 1'b0};
		w[25] = ^w[24:13];
		w[0]  = ~^w[12:1];
		return w;
	endfunction

	// leaves tvalid high after the accepting edge; the next call or settle() moves it on
	task automatic send_beat(input logic [1:0] mode, input logic [CODE_W-1:0] code,
			input logic [FAC_W-1:0] f, input logic [CARD_W-1:0] c);
		while (!calm && $urandom_range(99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= IN_DATA_W'({c, f, code});
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		beats_sent <= beats_sent + 1;
		case (mode)
			MODE_ATTEMPT: n_attempt++;
			MODE_APPEND:  n_append++;
			MODE_CLEAR:   n_clear++;
			default:      n_ignored++;
		endcase
	endtask

	task automatic attempt_raw(input logic [CODE_W-1:0] code);
		send_beat(MODE_ATTEMPT, code, FAC_W'($urandom), CARD_W'($urandom));
	endtask

	task automatic attempt(input logic [KEY_W-1:0] key);
		attempt_raw(wiegand(key[KEY_W-1:CARD_W], key[CARD_W-1:0]));
	endtask

	task automatic append(input logic [KEY_W-1:0] key);
		send_beat(MODE_APPEND, CODE_W'($urandom), key[KEY_W-1:CARD_W], key[CARD_W-1:0]);
		if (stored_keys.size() < DEPTH)
			stored_keys.push_back(key);
	endtask

	task automatic clear_table();
		send_beat(MODE_CLEAR, CODE_W'($urandom), FAC_W'($urandom), CARD_W'($urandom));
		stored_keys.delete();
	endtask

	task automatic noise_beat();
		send_beat(MODE_UNUSED, CODE_W'($urandom), FAC_W'($urandom), CARD_W'($urandom));
	endtask

	// drain everything, then allow for an unused-mode beat still being swallowed
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [CNT_W-1:0] value);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		n_cfg++;
	endtask

	task automatic random_attempt();
		int               roll;
		logic [KEY_W-1:0] key;
		roll = $urandom_range(99);
		if (stored_keys.size() > 0)
			key = stored_keys[$urandom_range(stored_keys.size() - 1)];
		else
			key = KEY_W'($urandom);
		if (roll < 55)
			attempt(key);
		else if (roll < 72)
			attempt(key ^ (KEY_W'(1) << $urandom_range(KEY_W - 1)));
		else if (roll < 82)
			attempt(KEY_W'($urandom));
		else if (roll < 92)
			case ($urandom_range(2))
				0:       attempt_raw(wiegand(key[KEY_W-1:CARD_W], key[CARD_W-1:0]) ^ BIT_EVEN);
				1:       attempt_raw(wiegand(key[KEY_W-1:CARD_W], key[CARD_W-1:0]) ^ BIT_ODD);
				default: attempt_raw(wiegand(key[KEY_W-1:CARD_W], key[CARD_W-1:0])
						^ BIT_EVEN ^ BIT_ODD);
			endcase
		else
			attempt_raw(CODE_W'($urandom));
	endtask

	initial begin : stimulus
		int episode;
		int target;
		int roll;
		logic [KEY_W-1:0] key;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, both parity halves, extreme codes and keys
		attempt({8'h00, 16'h0000});
		attempt_raw(wiegand(8'hFF, 16'hFFFF) ^ BIT_EVEN);
		attempt_raw(wiegand(8'hFF, 16'hFFFF) ^ BIT_ODD);
		append({8'hFF, 16'hFFFF});
		append({8'h00, 16'h0000});
		append({8'hA5, 16'h5A5A});
		attempt({8'hFF, 16'hFFFF});
		attempt({8'h00, 16'h0000});
		attempt({8'hA5, 16'h5A5A});
		attempt({8'hA5, 16'h5A5B});
		attempt_raw('1);
		attempt_raw('0);
		noise_beat();
		clear_table();
		// stale entries must not match after a clear
		attempt({8'hFF, 16'hFFFF});
		repeat (4) attempt_raw(wiegand(FAC_W'($urandom), CARD_W'($urandom)) ^ BIT_EVEN ^ BIT_ODD);
		append({8'h3C, 16'hC33C});
		attempt({8'h3C, 16'hC33C});

		write_threshold('0);
		target = n_attempt + n_append + n_clear + RANDOM_ITEMS;
		episode = 0;
		while (n_attempt + n_append + n_clear < target) begin
			episode++;
			calm <= (episode >= 40 && episode < 55);
			if (episode % 7 == 0) begin
				roll = $urandom_range(9);
				if (roll == 0)
					write_threshold('0);
				else if (roll == 1)
					write_threshold(CNT_MAX);
				else if (roll < 6)
					write_threshold(CNT_W'($urandom_range(1000)));
				else
					write_threshold(CNT_W'($urandom));
			end
			if ($urandom_range(3) == 0)
				clear_table();
			if (episode == 15) begin
				// fill to the brim, overflow, then search the whole table
				while (stored_keys.size() < DEPTH)
					append(KEY_W'($urandom));
				repeat (3) append(KEY_W'($urandom));
				attempt(stored_keys[DEPTH - 1]);
				repeat (5) random_attempt();
				clear_table();
			end else begin
				repeat ($urandom_range(1, 10)) begin
					if (stored_keys.size() > 0 && $urandom_range(9) == 0)
						append(stored_keys[$urandom_range(stored_keys.size() - 1)]);
					else
						append(KEY_W'($urandom));
				end
			end
			repeat ($urandom_range(4, 20)) begin
				if ($urandom_range(19) == 0)
					noise_beat();
				random_attempt();
			end
		end

		// a burst of grants, then of parity failures, with no idling
		settle();
		clear_table();
		key = KEY_W'($urandom);
		append(key);
		calm <= 1'b1;
		repeat (SAT_ROUNDS) attempt(key);
		repeat (SAT_ROUNDS) attempt_raw(wiegand(FAC_W'($urandom), CARD_W'($urandom)) ^ BIT_ODD);
		write_threshold(CNT_MAX);
		attempt(key);
		write_threshold(CNT_MAX - 1);
		attempt(key ^ KEY_W'(1));

		settle();
		$display("Run covered %0d access attempts, %0d appends, %0d clears, %0d unused-mode beats",
				n_attempt, n_append, n_clear, n_ignored);
		$display("and %0d threshold writes, with a full table; %0d results compared.",
				n_cfg, checked);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
